>>> hw/rtl/tdc_pkg.sv
package tdc_pkg;

  localparam int unsigned AngleW = 13;
  localparam int unsigned MagW   = 13;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned IdxW   = 4;

  // Full-scale magnitude: 90 degrees in 1/16 degree steps
  localparam logic [MagW-1:0] MAG_FULL = 13'd1440;
  localparam logic [7:0]      SPEED_MAX = 8'd255;

  localparam logic [ByteW-1:0] CH_LT    = 8'h3C; // '<'
  localparam logic [ByteW-1:0] CH_LPAR  = 8'h28; // '('
  localparam logic [ByteW-1:0] CH_RPAR  = 8'h29; // ')'
  localparam logic [ByteW-1:0] CH_GT    = 8'h3E; // '>'
  localparam logic [ByteW-1:0] CH_ZERO  = 8'h30; // '0'
  localparam logic [ByteW-1:0] CH_W     = 8'h57;
  localparam logic [ByteW-1:0] CH_S     = 8'h53;
  localparam logic [ByteW-1:0] CH_D     = 8'h44;
  localparam logic [ByteW-1:0] CH_A     = 8'h41;

  // direction and speed of one sample
  typedef struct packed {
    logic [ByteW-1:0] dir;
    logic [7:0]       speed;
  } spd_t;

  // everything the serializer needs for one frame
  typedef struct packed {
    logic [ByteW-1:0] dir;
    logic [3:0]       hund;
    logic [3:0]       tens;
    logic [3:0]       ones;
    logic [1:0]       ndig;   // 1..3
  } cmd_t;

endpackage

>>> hw/rtl/tdc_speed.sv
module tdc_speed (
  input  logic signed [tdc_pkg::AngleW-1:0] tilt_x,
  input  logic signed [tdc_pkg::AngleW-1:0] tilt_y,
  output tdc_pkg::spd_t                     spd
);

  logic [tdc_pkg::MagW-1:0]  ax;
  logic [tdc_pkg::MagW-1:0]  ay;
  logic [tdc_pkg::MagW-1:0]  mag;
  logic [tdc_pkg::ByteW-1:0] dir;
  logic [7:0]                speed;
  logic [10:0]               mag_lo;
  logic [14:0]               prod17;
  logic [9:0]                t;
  logic [18:0]               prod683;

  // -4096 maps to 4096 in the unsigned view
  assign ax = tilt_x[tdc_pkg::AngleW-1] ? 13'(-tilt_x) : 13'(tilt_x);
  assign ay = tilt_y[tdc_pkg::AngleW-1] ? 13'(-tilt_y) : 13'(tilt_y);

  always_comb begin
    if (ax > ay) begin
      mag = ax;
      dir = (!tilt_x[tdc_pkg::AngleW-1] && (tilt_x != '0)) ? tdc_pkg::CH_W : tdc_pkg::CH_S;
    end else begin
      mag = ay;
      dir = (!tilt_y[tdc_pkg::AngleW-1] && (tilt_y != '0)) ? tdc_pkg::CH_D : tdc_pkg::CH_A;
    end
  end

  // speed = floor(mag*17/96) = floor(floor(mag*17/32)/3); /3 as *683 >> 11, exact for t < 765
  assign mag_lo  = mag[10:0];
  assign prod17  = 15'(mag_lo) * 15'd17;
  assign t       = prod17[14:5];
  assign prod683 = 19'(t) * 19'd683;

  assign speed = (mag >= tdc_pkg::MAG_FULL) ? tdc_pkg::SPEED_MAX : prod683[18:11];

  assign spd = {dir, speed};

endmodule

>>> hw/rtl/tdc_digits.sv
module tdc_digits (
  input  tdc_pkg::spd_t spd,
  output tdc_pkg::cmd_t cmd
);

  logic [1:0]  h;
  logic [6:0]  rem;
  logic [14:0] prod205;
  logic [3:0]  tens;
  logic [6:0]  tens_x10;

  always_comb begin
    priority if (spd.speed >= 8'd200) begin
      h   = 2'd2;
      rem = 7'(spd.speed - 8'd200);
    end else if (spd.speed >= 8'd100) begin
      h   = 2'd1;
      rem = 7'(spd.speed - 8'd100);
    end else begin
      h   = 2'd0;
      rem = spd.speed[6:0];
    end
  end

  // rem/10 as *205 >> 11, exact below 100
  assign prod205  = 15'(rem) * 15'd205;
  assign tens     = prod205[14:11];
  assign tens_x10 = 7'(tens) * 7'd10;

  assign cmd.dir  = spd.dir;
  assign cmd.hund = {2'b00, h};
  assign cmd.tens = tens;
  assign cmd.ones = 4'(rem - tens_x10);
  assign cmd.ndig = (h != 2'd0) ? 2'd3 : ((tens != 4'd0) ? 2'd2 : 2'd1);

endmodule

>>> hw/rtl/tdc_frame_tx.sv
module tdc_frame_tx (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       load,
  input  tdc_pkg::cmd_t              cmd,
  output logic                       load_ok,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [tdc_pkg::ByteW-1:0]  out_frame_byte,
  output logic                       out_last_byte
);

  localparam logic [tdc_pkg::IdxW-1:0] POS_OPEN  = 4'd0;
  localparam logic [tdc_pkg::IdxW-1:0] POS_LPAR0 = 4'd1;
  localparam logic [tdc_pkg::IdxW-1:0] POS_DIR   = 4'd2;
  localparam logic [tdc_pkg::IdxW-1:0] POS_RPAR0 = 4'd3;
  localparam logic [tdc_pkg::IdxW-1:0] POS_LPAR1 = 4'd4;
  localparam logic [tdc_pkg::IdxW-1:0] POS_DIG   = 4'd5;
  localparam logic [tdc_pkg::IdxW-1:0] POS_TAIL  = 4'd6;

  tdc_pkg::cmd_t               frm_r;
  logic                        frm_v_r;
  logic [tdc_pkg::IdxW-1:0]    idx_r;
  logic [tdc_pkg::IdxW-1:0]    idx_nxt;
  logic [tdc_pkg::IdxW-1:0]    pos;
  logic [1:0]                  sel;
  logic [3:0]                  dig;
  logic                        beat;
  logic                        last;

  assign pos  = idx_r - POS_DIG;
  assign sel  = 2'(frm_r.ndig - 2'd1 - pos[1:0]);
  assign last = (idx_r == (POS_TAIL + 4'(frm_r.ndig)));
  assign beat = frm_v_r && !out_stall;

  assign load_ok = !frm_v_r || (beat && last);
  assign idx_nxt = idx_r + 4'd1;

  always_comb begin
    unique case (sel)
      2'd1:    dig = frm_r.tens;
      2'd2:    dig = frm_r.hund;
      default: dig = frm_r.ones;
    endcase
  end

  always_comb begin
    priority if (idx_r == POS_OPEN) begin
      out_frame_byte = tdc_pkg::CH_LT;
    end else if (idx_r == POS_LPAR0 || idx_r == POS_LPAR1) begin
      out_frame_byte = tdc_pkg::CH_LPAR;
    end else if (idx_r == POS_DIR) begin
      out_frame_byte = frm_r.dir;
    end else if (idx_r == POS_RPAR0) begin
      out_frame_byte = tdc_pkg::CH_RPAR;
    end else if (pos < 4'(frm_r.ndig)) begin
      out_frame_byte = tdc_pkg::CH_ZERO + {4'b0000, dig};
    end else if (pos == 4'(frm_r.ndig)) begin
      out_frame_byte = tdc_pkg::CH_RPAR;
    end else begin
      out_frame_byte = tdc_pkg::CH_GT;
    end
  end

  assign out_valid     = frm_v_r;
  assign out_last_byte = last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frm_v_r <= 1'b0;
      idx_r   <= POS_OPEN;
    end else if (load) begin
      frm_v_r <= 1'b1;
      idx_r   <= POS_OPEN;
    end else if (beat) begin
      if (last) begin
        frm_v_r <= 1'b0;
        idx_r   <= POS_OPEN;
      end else begin
        idx_r   <= idx_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      frm_r <= cmd;
    end
  end

endmodule

>>> hw/rtl/tilt_to_drive_command_frame.sv
// Channel | Ports                                   | Direction
// input   | in_valid, in_stall, in_tilt_x, in_tilt_y | tilt sample in
// output  | out_valid, out_stall, out_frame_byte,   | frame bytes out,
//         | out_last_byte                           | one byte per beat
//
// Each sample yields a frame of 8 to 10 byte beats, 7 plus the number of
// speed digits; the byte serializer sets the rate, one sample per frame.
// The first byte reaches the port through the input reg, speed reg and
// frame reg, in that order. Two samples can queue behind the frame being
// sent.
// rst_n is synchronous, active low; it empties all stages.
// out_stall holds the current byte; backpressure reaches in_stall once
// the input and speed registers are both occupied and the frame register cannot load.
module tilt_to_drive_command_frame (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [tdc_pkg::AngleW-1:0]   in_tilt_x,
  input  logic signed [tdc_pkg::AngleW-1:0]   in_tilt_y,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [tdc_pkg::ByteW-1:0]           out_frame_byte,
  output logic                                out_last_byte
);

  // input register
  logic signed [tdc_pkg::AngleW-1:0] tilt_x_r;
  logic signed [tdc_pkg::AngleW-1:0] tilt_y_r;
  logic                              in_v_r;

  // speed register
  tdc_pkg::spd_t spd_nxt;
  tdc_pkg::spd_t spd_r;
  logic          spd_v_r;

  tdc_pkg::cmd_t cmd;
  logic          load_ok;
  logic          spd_adv;
  logic          spd_ok;
  logic          in_adv;
  logic          in_take;

  // stage handshakes: a stage moves on when the one after it is free
  // or being freed this cycle
  assign spd_adv  = spd_v_r && load_ok;
  assign spd_ok   = !spd_v_r || spd_adv;
  assign in_adv   = in_v_r && spd_ok;
  assign in_stall = in_v_r && !spd_ok;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      spd_v_r <= 1'b0;
    end else begin
      if (in_take) begin
        in_v_r <= 1'b1;
      end else if (in_adv) begin
        in_v_r <= 1'b0;
      end
      if (in_adv) begin
        spd_v_r <= 1'b1;
      end else if (spd_adv) begin
        spd_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      tilt_x_r <= in_tilt_x;
      tilt_y_r <= in_tilt_y;
    end
    if (in_adv) begin
      spd_r <= spd_nxt;
    end
  end

  // winning axis, direction letter, scaled and clamped speed
  tdc_speed u_speed (
    .tilt_x (tilt_x_r),
    .tilt_y (tilt_y_r),
    .spd    (spd_nxt)
  );

  // decimal split of the speed
  tdc_digits u_digits (
    .spd (spd_r),
    .cmd (cmd)
  );

  // frame register and byte serializer
  tdc_frame_tx u_tx (
    .clk            (clk),
    .rst_n          (rst_n),
    .load           (spd_adv),
    .cmd            (cmd),
    .load_ok        (load_ok),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_frame_byte (out_frame_byte),
    .out_last_byte  (out_last_byte)
  );

  // closing byte of every frame is '>'
  a_last_is_gt : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_byte |-> out_frame_byte == tdc_pkg::CH_GT)
    else $error("last byte is not the closing bracket");

  // a frame ending is followed only by a fresh frame start
  a_next_frame_opens : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_last_byte |=>
      !out_valid || out_frame_byte == tdc_pkg::CH_LT)
    else $error("frame does not start with open bracket");

  // the opening bracket is always followed by '('
  a_open_then_lpar : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_frame_byte == tdc_pkg::CH_LT && !out_last_byte |=>
      out_valid && out_frame_byte == tdc_pkg::CH_LPAR)
    else $error("open bracket not followed by parenthesis");

  // a held input sample is kept while backpressure stands
  a_in_hold : assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> in_v_r && $stable(tilt_x_r) && $stable(tilt_y_r))
    else $error("input register changed while stalled");

endmodule
